// ----- hw/rtl/dhtq_pkg.sv -----
// shared types and constants for the deadline heap timer queue
package dhtq_pkg;

   localparam int QueueDepthDefault = 32;
   localparam int TaskIdBitsDefault = 16;
   localparam int NowBits           = 64;
   localparam int DelayBits         = 32;
   localparam int TaskPortBits      = 16;
   localparam int WaitBits          = 32;
   localparam int OrderBits         = 32;
   localparam int FifoDepth         = 2;

   typedef enum logic [1:0] {
      KIND_ADD_OK   = 2'd0,
      KIND_ADD_FULL = 2'd1,
      KIND_EXPIRED  = 2'd2,
      KIND_WAIT     = 2'd3
   } kind_type;

   typedef enum logic {
      CMD_ADD  = 1'b0,
      CMD_TICK = 1'b1
   } cmd_type;

   // classified request handed from front to back
   typedef struct packed {
      cmd_type                cmd;
      logic [NowBits-1:0]     now;
      logic [NowBits-1:0]     deadline;
      logic [TaskPortBits-1:0] task_id;
   } op_type;

endpackage

// ----- hw/rtl/dhtq_front.sv -----
// front end: accepts requests, computes the saturated deadline, queues the op
module dhtq_front
   import dhtq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   input  logic [NowBits-1:0]       req_now_us,
   input  logic [DelayBits-1:0]     req_delay_us,
   input  logic [TaskPortBits-1:0]  req_task_id,
   output logic                     op_valid,
   input  logic                     op_ready,
   output op_type                   op
);

   op_type        fifo_ff [FifoDepth];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   logic [NowBits:0] sum;
   op_type        new_op;
   logic          push, pop;

   // saturated deadline
   always_comb begin
      sum = {1'b0, req_now_us} + {{(NowBits-DelayBits+1){1'b0}}, req_delay_us};
      new_op.cmd      = cmd_type'(req_command);
      new_op.now      = req_now_us;
      new_op.deadline = sum[NowBits] ? {NowBits{1'b1}} : sum[NowBits-1:0];
      new_op.task_id  = req_task_id;
   end

   assign req_ready = (count_ff != 2'(FifoDepth));
   assign push      = req_valid && req_ready;
   assign op_valid  = (count_ff != 2'd0);
   assign pop       = op_valid && op_ready;
   assign op        = fifo_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_op;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'(FifoDepth) |-> !push) else $error("queue overflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(FifoDepth)) else $error("queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0) else $error("pop from empty queue");
`endif

endmodule

// ----- hw/rtl/dhtq_back.sv -----
// back end: heap engine with sift sequencer and result register
module dhtq_back
   import dhtq_pkg::*;
#(
   parameter int QUEUE_DEPTH  = QueueDepthDefault,
   parameter int TASK_ID_BITS = TaskIdBitsDefault
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     op_valid,
   output logic                     op_ready,
   input  op_type                   op,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_kind,
   output logic [TaskPortBits-1:0]  rsp_task_id_out,
   output logic [WaitBits-1:0]      rsp_wait_us,
   output logic                     rsp_last
);

   localparam int IdxBits = $clog2(QUEUE_DEPTH);
   localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_TICK_RD,
      ST_TICK_CHK,
      ST_MOVE_RD,
      ST_DN_RD,
      ST_DN_CMP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [NowBits-1:0]      dl;
      logic [TASK_ID_BITS-1:0] tid;
      logic [OrderBits-1:0]    ord;
   } slot_type;

   // heap memory, one write port, two registered read ports
   slot_type heap_mem [QUEUE_DEPTH];
   slot_type rd_a_ff, rd_b_ff;
   logic [IdxBits-1:0] ra_addr, rb_addr;
   logic               we;
   logic [IdxBits-1:0] wa;
   slot_type           wd;

   always_ff @(posedge clock) begin
      if (we) begin
         heap_mem[wa] <= wd;
      end
      rd_a_ff <= heap_mem[ra_addr];
      rd_b_ff <= heap_mem[rb_addr];
   end

   state_type            state_ff;
   op_type               op_ff;
   logic [CntBits-1:0]   count_ff;
   logic [OrderBits-1:0] seq_ff;
   logic [IdxBits-1:0]   pos_ff;
   slot_type             cur_ff;
   logic                 right_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_kind_ff;
   logic [TaskPortBits-1:0] rsp_task_ff;
   logic [WaitBits-1:0]  rsp_wait_ff;
   logic                 rsp_last_ff;
   logic                 after_out_ff;   // 0: done after output, 1: continue tick

   // true when a must leave before b
   function automatic logic earlier(slot_type a, slot_type b);
      logic [OrderBits-1:0] d;
      begin
         d = a.ord - b.ord;
         earlier = (a.dl != b.dl) ? (a.dl < b.dl) : d[OrderBits-1];
      end
   endfunction

   // child and parent indices of the current position
   logic [CntBits:0] left_idx, right_idx, parent_idx;
   assign left_idx   = {CntBits'(pos_ff), 1'b1};
   assign right_idx  = {CntBits'(pos_ff) + CntBits'(1), 1'b0};
   assign parent_idx = {1'b0, (CntBits'(pos_ff) - CntBits'(1)) >> 1};

   logic has_left, has_right;
   assign has_left  = left_idx  < (CntBits+1)'(count_ff);
   assign has_right = right_idx < (CntBits+1)'(count_ff);

   // read address selection
   always_comb begin
      ra_addr = '0;
      rb_addr = '0;
      unique case (state_ff)
         ST_UP_RD:   ra_addr = IdxBits'(parent_idx);
         ST_MOVE_RD: ra_addr = IdxBits'(count_ff);
         ST_DN_RD: begin
            ra_addr = IdxBits'(left_idx);
            rb_addr = IdxBits'(right_idx);
         end
         default: begin
            ra_addr = '0;
            rb_addr = '0;
         end
      endcase
   end

   // wait computation from the root
   logic [NowBits-1:0] diff;
   logic [WaitBits-1:0] wait_val;
   assign diff     = rd_a_ff.dl - op_ff.now;
   assign wait_val = (diff[NowBits-1:WaitBits] != '0) ? {WaitBits{1'b1}}
                                                      : diff[WaitBits-1:0];

   // chosen child for sift down
   slot_type child;
   logic     pick_right, child_first;
   always_comb begin
      pick_right  = has_right && earlier(rd_b_ff, rd_a_ff);
      child       = pick_right ? rd_b_ff : rd_a_ff;
      child_first = has_left && earlier(child, cur_ff);
   end

   // memory write control
   always_comb begin
      we = 1'b0;
      wa = pos_ff;
      wd = cur_ff;
      unique case (state_ff)
         ST_UP_CMP: begin
            we = 1'b1;
            if (pos_ff != '0 && earlier(cur_ff, rd_a_ff)) begin
               wd = rd_a_ff;
            end
         end
         ST_DN_CMP: begin
            we = 1'b1;
            if (child_first) begin
               wd = child;
            end
         end
         default: we = 1'b0;
      endcase
   end

   assign op_ready        = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_task_id_out = rsp_task_ff;
   assign rsp_wait_us     = rsp_wait_ff;
   assign rsp_last        = rsp_last_ff;

   // sequencer with registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         seq_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         after_out_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (op_valid) begin
                  op_ff <= op;
                  if (op.cmd == CMD_ADD) begin
                     if (count_ff == CntBits'(QUEUE_DEPTH)) begin
                        rsp_kind_ff  <= KIND_ADD_FULL;
                        rsp_task_ff  <= '0;
                        rsp_wait_ff  <= '0;
                        rsp_last_ff  <= 1'b1;
                        rsp_valid_ff <= 1'b1;
                        after_out_ff <= 1'b0;
                        state_ff     <= ST_OUT;
                     end else begin
                        pos_ff     <= IdxBits'(count_ff);
                        cur_ff.dl  <= op.deadline;
                        cur_ff.tid <= TASK_ID_BITS'(op.task_id);
                        cur_ff.ord <= seq_ff;
                        seq_ff     <= seq_ff + 1'b1;
                        count_ff   <= count_ff + 1'b1;
                        state_ff   <= ST_UP_RD;
                     end
                  end else begin
                     state_ff <= ST_TICK_RD;
                  end
               end
            end
            ST_UP_RD: state_ff <= ST_UP_CMP;
            ST_UP_CMP: begin
               if (pos_ff != '0 && earlier(cur_ff, rd_a_ff)) begin
                  pos_ff   <= IdxBits'(parent_idx);
                  state_ff <= ST_UP_RD;
               end else begin
                  rsp_kind_ff  <= KIND_ADD_OK;
                  rsp_task_ff  <= '0;
                  rsp_wait_ff  <= '0;
                  rsp_last_ff  <= 1'b1;
                  rsp_valid_ff <= 1'b1;
                  after_out_ff <= 1'b0;
                  state_ff     <= ST_OUT;
               end
            end
            ST_TICK_RD: state_ff <= ST_TICK_CHK;
            ST_TICK_CHK: begin
               rsp_valid_ff <= 1'b1;
               if (count_ff != '0 && rd_a_ff.dl <= op_ff.now) begin
                  rsp_kind_ff  <= KIND_EXPIRED;
                  rsp_task_ff  <= TaskPortBits'(rd_a_ff.tid);
                  rsp_wait_ff  <= '0;
                  rsp_last_ff  <= 1'b0;
                  after_out_ff <= 1'b1;
                  count_ff     <= count_ff - 1'b1;
               end else begin
                  rsp_kind_ff  <= KIND_WAIT;
                  rsp_task_ff  <= '0;
                  rsp_wait_ff  <= (count_ff != '0) ? wait_val : '0;
                  rsp_last_ff  <= 1'b1;
                  after_out_ff <= 1'b0;
               end
               state_ff <= ST_OUT;
            end
            ST_MOVE_RD: state_ff <= ST_DN_RD;
            ST_DN_RD: begin
               // first pass holds the moved last entry
               if (right_ff) begin
                  cur_ff   <= rd_a_ff;
                  right_ff <= 1'b0;
               end
               state_ff <= ST_DN_CMP;
            end
            ST_DN_CMP: begin
               if (child_first) begin
                  pos_ff   <= pick_right ? IdxBits'(right_idx) : IdxBits'(left_idx);
                  state_ff <= ST_DN_RD;
               end else begin
                  state_ff <= ST_TICK_RD;
               end
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (!after_out_ff) begin
                     state_ff <= ST_IDLE;
                  end else if (count_ff == '0) begin
                     state_ff <= ST_TICK_RD;
                  end else begin
                     pos_ff   <= '0;
                     right_ff <= 1'b1;
                     state_ff <= ST_MOVE_RD;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntBits'(QUEUE_DEPTH)) else $error("heap count overflow");
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_OUT) else $error("result outside output state");
   a_full_no_grow: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE && op_valid && op.cmd == CMD_ADD
      && count_ff == CntBits'(QUEUE_DEPTH) |=> count_ff == CntBits'(QUEUE_DEPTH))
      else $error("full heap grew");
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_kind_ff))
      else $error("result dropped while stalled");
`endif

endmodule

// ----- hw/rtl/deadline_heap_timer_queue_unit.sv -----
// top level of the deadline heap timer queue
//
//  channel | direction | handshake            | fields
//  req     | in        | req_valid/req_ready  | command, now_us, delay_us, task_id
//  rsp     | out       | rsp_valid/rsp_ready  | kind, task_id_out, wait_us, last
//
// an add sifts up through heap memory, each level a registered read then a
//   compare and write
// a tick ends with a wait report; each expired task before it is reported and
//   then followed by a sift down with both children read in the same cycle
// a two-entry request queue lets the front keep accepting while the heap works
// reset is synchronous; heap memory needs no clearing pass
// a stalled result holds the heap sequencer until taken
module deadline_heap_timer_queue_unit
   import dhtq_pkg::*;
#(
   parameter int QUEUE_DEPTH  = QueueDepthDefault,
   parameter int TASK_ID_BITS = TaskIdBitsDefault
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_command,
   input  logic [NowBits-1:0]       req_now_us,
   input  logic [DelayBits-1:0]     req_delay_us,
   input  logic [TaskPortBits-1:0]  req_task_id,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_kind,
   output logic [TaskPortBits-1:0]  rsp_task_id_out,
   output logic [WaitBits-1:0]      rsp_wait_us,
   output logic                     rsp_last
);

   op_type op;
   logic   op_valid, op_ready;

   // request front end
   dhtq_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_now_us   (req_now_us),
      .req_delay_us (req_delay_us),
      .req_task_id  (req_task_id),
      .op_valid     (op_valid),
      .op_ready     (op_ready),
      .op           (op)
   );

   // heap back end
   dhtq_back #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .op_valid        (op_valid),
      .op_ready        (op_ready),
      .op              (op),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_task_id_out (rsp_task_id_out),
      .rsp_wait_us     (rsp_wait_us),
      .rsp_last        (rsp_last)
   );

endmodule
